// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the quaternion rotate unit
// expects i_clk and i_rst_n in the scope of use; empty when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QR_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrot assertion failed");
`define QR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrot assertion failed");
`else
`define QR_ASSERT(lbl, ante, cons)
`define QR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/qrot_pkg.sv =====
// shared types and constants for the quaternion rotate unit
// no dependencies
`default_nettype none
package qrot_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    // product, matrix, norm, mac, remainder and quotient widths
    localparam int PW = 2 * DATA_WIDTH;
    localparam int CW = 2 * DATA_WIDTH + 2;
    localparam int NW = 2 * DATA_WIDTH + 1;
    localparam int MW = CW + DATA_WIDTH;
    localparam int RW = MW + 2;
    localparam int QW = DATA_WIDTH + 2;
    localparam int IDX_WIDTH = 2;

    // register indexes
    localparam logic [IDX_WIDTH-1:0] REG_ROT_S = 2'd0;
    localparam logic [IDX_WIDTH-1:0] REG_ROT_X = 2'd1;
    localparam logic [IDX_WIDTH-1:0] REG_ROT_Y = 2'd2;
    localparam logic [IDX_WIDTH-1:0] REG_ROT_Z = 2'd3;

    localparam logic signed [DATA_WIDTH-1:0] ROT_S_RESET = DATA_WIDTH'(1 << FRAC_BITS);

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef struct packed {
        t_word in_scalar;
        t_word in_x;
        t_word in_y;
        t_word in_z;
    } t_qrot_in;

    typedef struct packed {
        t_word out_scalar;
        t_word out_x;
        t_word out_y;
        t_word out_z;
        logic  saturated;
        logic  degenerate;
    } t_qrot_out;

    // pipeline control handed to the coef, mac and divide step modules
    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage
`default_nettype wire

// ===== rtl/quaternion_rotate_unit.sv =====
// top level of the quaternion rotate unit: registers, pipeline, output stage
// depends on qrot_pkg, qrot_coef, qrot_mac, qrot_div_step, assert_macros.svh
//
// Rotates each operand p by the stored quaternion q as q * p * q^-1.
// Input channel: i_in_valid / o_in_ready with payload i_data (scalar, x, y, z).
// Output channel: o_out_valid / i_out_ready with payload o_data, carrying the
// rotated operand plus saturated and degenerate flags. The scalar passes
// through unchanged (zero when degenerate); vector components are rounded to
// nearest, ties away from zero, then clamped to 16 bits.
// Rotation registers are written through i_cfg_we / i_cfg_index / i_cfg_wdata
// and must only change while no transaction is in flight.
// The pipeline has two stages for the matrix, two for the products and
// row sums, eighteen restoring divide steps (one quotient bit each) and the
// output register. One transaction is taken every cycle unless the output stalls.
// Reset clears all valid bits and loads the identity rotation.
// When the receiver stalls the whole pipeline holds, nothing is dropped, and
// o_in_ready falls until the output transaction is taken.
`default_nettype none
`include "assert_macros.svh"
module quaternion_rotate_unit (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_we,
    input  wire [qrot_pkg::IDX_WIDTH-1:0]          i_cfg_index,
    input  wire [qrot_pkg::DATA_WIDTH-1:0]         i_cfg_wdata,
    input  wire                                    i_in_valid,
    output logic                                   o_in_ready,
    input  qrot_pkg::t_qrot_in                     i_data,
    output logic                                   o_out_valid,
    input  wire                                    i_out_ready,
    output qrot_pkg::t_qrot_out                    o_data
);
    localparam int DW = qrot_pkg::DATA_WIDTH;
    localparam int CW = qrot_pkg::CW;
    localparam int NW = qrot_pkg::NW;
    localparam int RW = qrot_pkg::RW;
    localparam int QW = qrot_pkg::QW;
    localparam logic signed [QW:0] V_HI = (QW+1)'((2 ** (DW - 1)) - 1);
    localparam logic signed [QW:0] V_LO = -V_HI - 1;

    qrot_pkg::t_word r_rot_s, r_rot_x, r_rot_y, r_rot_z;
    logic en;
    qrot_pkg::t_pipe_ctl ctl_in, ctl_mac;

    logic coef_valid, coef_degen;
    logic signed [8:0][CW-1:0] coef_mat;
    logic [NW-1:0] coef_norm;
    qrot_pkg::t_qrot_in coef_data;

    logic [QW:0] dv_valid;
    logic [QW:0][2:0][RW-1:0] dv_rem;
    logic [QW:0][2:0][QW-1:0] dv_quo;
    logic [QW:0][2:0] dv_neg;
    logic [QW:0][NW-1:0] dv_norm;
    logic [QW:0] dv_degen;
    qrot_pkg::t_word dv_scalar [QW+1];
    qrot_pkg::t_pipe_ctl dv_ctl [QW];

    logic signed [QW:0] val [3];
    qrot_pkg::t_word n_comp [3];
    logic n_sat;
    qrot_pkg::t_qrot_out n_out;

    // rotation registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_s <= qrot_pkg::ROT_S_RESET;
            r_rot_x <= '0;
            r_rot_y <= '0;
            r_rot_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                qrot_pkg::REG_ROT_S: r_rot_s <= i_cfg_wdata;
                qrot_pkg::REG_ROT_X: r_rot_x <= i_cfg_wdata;
                qrot_pkg::REG_ROT_Y: r_rot_y <= i_cfg_wdata;
                qrot_pkg::REG_ROT_Z: r_rot_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: move unless a result waits at the output
    assign en = !o_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign ctl_in  = '{en: en, valid: i_in_valid};
    assign ctl_mac = '{en: en, valid: coef_valid};

    qrot_coef u_coef (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_in),
        .i_rot_s (r_rot_s),
        .i_rot_x (r_rot_x),
        .i_rot_y (r_rot_y),
        .i_rot_z (r_rot_z),
        .i_data  (i_data),
        .o_valid (coef_valid),
        .o_mat   (coef_mat),
        .o_norm  (coef_norm),
        .o_degen (coef_degen),
        .o_data  (coef_data)
    );

    qrot_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_mac),
        .i_mat    (coef_mat),
        .i_norm   (coef_norm),
        .i_degen  (coef_degen),
        .i_data   (coef_data),
        .o_valid  (dv_valid[QW]),
        .o_rem    (dv_rem[QW]),
        .o_neg    (dv_neg[QW]),
        .o_norm   (dv_norm[QW]),
        .o_degen  (dv_degen[QW]),
        .o_scalar (dv_scalar[QW])
    );
    assign dv_quo[QW] = '0;

    // divide chain, step b produces quotient bit b, highest bit first in time
    for (genvar b = 0; b < QW; b++) begin : g_div
        assign dv_ctl[b] = '{en: en, valid: dv_valid[b+1]};

        qrot_div_step #(.BIT(b)) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (dv_ctl[b]),
            .i_rem    (dv_rem[b+1]),
            .i_quo    (dv_quo[b+1]),
            .i_neg    (dv_neg[b+1]),
            .i_norm   (dv_norm[b+1]),
            .i_degen  (dv_degen[b+1]),
            .i_scalar (dv_scalar[b+1]),
            .o_valid  (dv_valid[b]),
            .o_rem    (dv_rem[b]),
            .o_quo    (dv_quo[b]),
            .o_neg    (dv_neg[b]),
            .o_norm   (dv_norm[b]),
            .o_degen  (dv_degen[b]),
            .o_scalar (dv_scalar[b])
        );
    end

    // sign restore, clamp and flags
    always_comb begin
        n_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            val[i] = dv_neg[0][i] ? -signed'({1'b0, dv_quo[0][i]})
                                  : signed'({1'b0, dv_quo[0][i]});
            if (val[i] > V_HI) begin
                n_comp[i] = DW'(V_HI);
                n_sat = 1'b1;
            end else if (val[i] < V_LO) begin
                n_comp[i] = DW'(V_LO);
                n_sat = 1'b1;
            end else begin
                n_comp[i] = DW'(val[i]);
            end
        end
        if (dv_degen[0]) begin
            n_out = '0;
            n_out.degenerate = 1'b1;
        end else begin
            n_out.out_scalar = dv_scalar[0];
            n_out.out_x      = n_comp[0];
            n_out.out_y      = n_comp[1];
            n_out.out_z      = n_comp[2];
            n_out.saturated  = n_sat;
            n_out.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= dv_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_data <= n_out;
        end
    end

    // checks
    `QR_ASSERT(a_degen_zero, o_out_valid && o_data.degenerate, o_data.out_x == '0 && o_data.out_y == '0 && o_data.out_z == '0 && !o_data.saturated)
    `QR_ASSERT(a_flags_excl, o_out_valid, !(o_data.saturated && o_data.degenerate))
    `QR_ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(o_data))
    `QR_ASSERT(a_ready_rule, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))
endmodule
`default_nettype wire

// ===== rtl/qrot_coef.sv =====
// rotation matrix and squared norm from the rotation registers, two stages
// depends on qrot_pkg
`default_nettype none
module qrot_coef (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  qrot_pkg::t_pipe_ctl                i_ctl,
    input  qrot_pkg::t_word                    i_rot_s,
    input  qrot_pkg::t_word                    i_rot_x,
    input  qrot_pkg::t_word                    i_rot_y,
    input  qrot_pkg::t_word                    i_rot_z,
    input  qrot_pkg::t_qrot_in                 i_data,
    output logic                               o_valid,
    output logic signed [8:0][qrot_pkg::CW-1:0] o_mat,
    output logic [qrot_pkg::NW-1:0]            o_norm,
    output logic                               o_degen,
    output qrot_pkg::t_qrot_in                 o_data
);
    localparam int PW = qrot_pkg::PW;
    localparam int CW = qrot_pkg::CW;
    localparam int NW = qrot_pkg::NW;

    logic r_valid_a;
    logic signed [PW-1:0] r_ss, r_xx, r_yy, r_zz, r_xy, r_sz, r_xz, r_sy, r_yz, r_sx;
    qrot_pkg::t_qrot_in r_data_a;
    logic signed [CW-1:0] ss, xx, yy, zz, xy, sz, xz, sy, yz, sx;
    logic signed [8:0][CW-1:0] n_mat;
    logic [NW-1:0] n_norm;

    // stage a: pairwise products of the rotation components
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid_a <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ss <= i_rot_s * i_rot_s;
            r_xx <= i_rot_x * i_rot_x;
            r_yy <= i_rot_y * i_rot_y;
            r_zz <= i_rot_z * i_rot_z;
            r_xy <= i_rot_x * i_rot_y;
            r_sz <= i_rot_s * i_rot_z;
            r_xz <= i_rot_x * i_rot_z;
            r_sy <= i_rot_s * i_rot_y;
            r_yz <= i_rot_y * i_rot_z;
            r_sx <= i_rot_s * i_rot_x;
            r_data_a <= i_data;
        end
    end

    // stage b: matrix entries and norm
    always_comb begin
        ss = CW'(r_ss); xx = CW'(r_xx); yy = CW'(r_yy); zz = CW'(r_zz);
        xy = CW'(r_xy); sz = CW'(r_sz); xz = CW'(r_xz); sy = CW'(r_sy);
        yz = CW'(r_yz); sx = CW'(r_sx);
        n_mat[0] = ss + xx - yy - zz;
        n_mat[1] = (xy - sz) <<< 1;
        n_mat[2] = (xz + sy) <<< 1;
        n_mat[3] = (xy + sz) <<< 1;
        n_mat[4] = ss - xx + yy - zz;
        n_mat[5] = (yz - sx) <<< 1;
        n_mat[6] = (xz - sy) <<< 1;
        n_mat[7] = (yz + sx) <<< 1;
        n_mat[8] = ss - xx - yy + zz;
        n_norm   = NW'(ss + xx + yy + zz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_mat   <= n_mat;
            o_norm  <= n_norm;
            o_degen <= (n_norm == '0);
            o_data  <= r_data_a;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/qrot_mac.sv =====
// matrix times vector, then magnitude plus half the norm for rounding, two stages
// depends on qrot_pkg
`default_nettype none
module qrot_mac (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  qrot_pkg::t_pipe_ctl                 i_ctl,
    input  logic signed [8:0][qrot_pkg::CW-1:0] i_mat,
    input  logic [qrot_pkg::NW-1:0]             i_norm,
    input  logic                                i_degen,
    input  qrot_pkg::t_qrot_in                  i_data,
    output logic                                o_valid,
    output logic [2:0][qrot_pkg::RW-1:0]        o_rem,
    output logic [2:0]                          o_neg,
    output logic [qrot_pkg::NW-1:0]             o_norm,
    output logic                                o_degen,
    output qrot_pkg::t_word                     o_scalar
);
    localparam int CW = qrot_pkg::CW;
    localparam int MW = qrot_pkg::MW;
    localparam int RW = qrot_pkg::RW;
    localparam int NW = qrot_pkg::NW;

    logic r_valid_c;
    logic signed [8:0][MW-1:0] r_prod;
    logic [NW-1:0] r_norm_c;
    logic r_degen_c;
    qrot_pkg::t_word r_scalar_c;
    qrot_pkg::t_word p [3];
    logic signed [RW-1:0] acc [3];
    logic [2:0][RW-1:0] n_rem;
    logic [2:0] n_neg;

    assign p[0] = i_data.in_x;
    assign p[1] = i_data.in_y;
    assign p[2] = i_data.in_z;

    // stage c: nine products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid_c <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= MW'(signed'(i_mat[k]) * p[k % 3]);
            end
            r_norm_c   <= i_norm;
            r_degen_c  <= i_degen;
            r_scalar_c <= i_data.in_scalar;
        end
    end

    // stage d: row sums, sign and rounding offset
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = RW'(signed'(r_prod[3*i])) + RW'(signed'(r_prod[3*i+1]))
                   + RW'(signed'(r_prod[3*i+2]));
            n_neg[i] = acc[i][RW-1];
            n_rem[i] = (n_neg[i] ? RW'(-acc[i]) : RW'(acc[i])) + RW'(r_norm_c >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= r_valid_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_rem    <= n_rem;
            o_neg    <= n_neg;
            o_norm   <= r_norm_c;
            o_degen  <= r_degen_c;
            o_scalar <= r_scalar_c;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/qrot_div_step.sv =====
// one restoring division step for three lanes, one quotient bit per stage
// depends on qrot_pkg
`default_nettype none
module qrot_div_step #(
    parameter int BIT = 0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  qrot_pkg::t_pipe_ctl            i_ctl,
    input  logic [2:0][qrot_pkg::RW-1:0]   i_rem,
    input  logic [2:0][qrot_pkg::QW-1:0]   i_quo,
    input  logic [2:0]                     i_neg,
    input  logic [qrot_pkg::NW-1:0]        i_norm,
    input  logic                           i_degen,
    input  qrot_pkg::t_word                i_scalar,
    output logic                           o_valid,
    output logic [2:0][qrot_pkg::RW-1:0]   o_rem,
    output logic [2:0][qrot_pkg::QW-1:0]   o_quo,
    output logic [2:0]                     o_neg,
    output logic [qrot_pkg::NW-1:0]        o_norm,
    output logic                           o_degen,
    output qrot_pkg::t_word                o_scalar
);
    localparam int RW = qrot_pkg::RW;

    logic [RW-1:0] shifted;
    logic [2:0][RW-1:0] n_rem;
    logic [2:0][qrot_pkg::QW-1:0] n_quo;

    // compare against the shifted divisor and subtract where it fits
    always_comb begin
        shifted = RW'(i_norm) << BIT;
        n_rem = i_rem;
        n_quo = i_quo;
        for (int l = 0; l < 3; l++) begin
            if (i_rem[l] >= shifted) begin
                n_rem[l] = i_rem[l] - shifted;
                n_quo[l][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_ctl.en) begin
            o_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            o_rem    <= n_rem;
            o_quo    <= n_quo;
            o_neg    <= i_neg;
            o_norm   <= i_norm;
            o_degen  <= i_degen;
            o_scalar <= i_scalar;
        end
    end
endmodule
`default_nettype wire
